FILE: hdl/vn_pkg.sv
package vn_pkg;

	// default configuration of the core
	localparam int COMP_WIDTH_DEF    = 32;
	localparam int OUT_FRAC_BITS_DEF = 30;

	// lane control: advance strobe of the shared pipeline
	typedef struct packed {
		logic en;
	} lane_ctl_t;

endpackage

FILE: hdl/vn_div.sv
module vn_div #(
	parameter int COMP_WIDTH    = vn_pkg::COMP_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  vn_pkg::lane_ctl_t                   ctl,
	input  logic [2*COMP_WIDTH-1:0]             sq,
	input  logic [2*COMP_WIDTH-1:0]             sum,
	input  logic                                tag_in,
	output logic [2*OUT_FRAC_BITS:0]            quo,
	output logic                                tag_out
);
	import vn_pkg::*;

	localparam int SW = 2 * COMP_WIDTH;
	localparam int QW = 2 * OUT_FRAC_BITS + 1;

	// restoring division of sq * 2^(2F) by sum, one quotient bit per stage
	logic [SW-1:0] rem_s [QW];
	logic [SW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic          tag_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [SW-1:0] rem_in;
		logic [SW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic          tag_in_k;
		logic          bit_in;
		logic [SW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			// low bits of the dividend are all zero except the last bit of sq
			assign rem_in   = {1'b0, sq[SW-1:1]};
			assign bit_in   = sq[0];
			assign den_in   = sum;
			assign quo_in   = '0;
			assign tag_in_k = tag_in;
		end else begin : g_next
			assign rem_in   = rem_s[k-1];
			assign bit_in   = 1'b0;
			assign den_in   = den_s[k-1];
			assign quo_in   = quo_s[k-1];
			assign tag_in_k = tag_s[k-1];
		end

		assign trial = {rem_in, bit_in};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[k] <= ge ? SW'(trial - {1'b0, den_in}) : trial[SW-1:0];
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[QW-2:0], ge};
				tag_s[k] <= tag_in_k;
			end
		end
	end

	assign quo     = quo_s[QW-1];
	assign tag_out = tag_s[QW-1];

endmodule

FILE: hdl/vn_sqrt.sv
module vn_sqrt #(
	parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  vn_pkg::lane_ctl_t            ctl,
	input  logic [2*OUT_FRAC_BITS:0]     rad,
	input  logic                         tag_in,
	output logic [OUT_FRAC_BITS:0]       root,
	output logic                         tag_out
);
	import vn_pkg::*;

	localparam int QW = 2 * OUT_FRAC_BITS + 1;
	localparam int RW = OUT_FRAC_BITS + 1;
	localparam int NS = OUT_FRAC_BITS + 1;

	// integer square root, one root bit per stage, r holds rad - root^2
	logic [QW-1:0] r_s   [NS];
	logic [RW-1:0] q_s   [NS];
	logic          tag_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int B = OUT_FRAC_BITS - j;
		logic [QW-1:0] r_in;
		logic [RW-1:0] q_in;
		logic          tag_in_j;
		logic [QW:0]   term;
		logic          ge;

		if (j == 0) begin : g_first
			assign r_in     = rad;
			assign q_in     = '0;
			assign tag_in_j = tag_in;
		end else begin : g_next
			assign r_in     = r_s[j-1];
			assign q_in     = q_s[j-1];
			assign tag_in_j = tag_s[j-1];
		end

		// (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
		assign term = ({{(QW+1-RW){1'b0}}, q_in} << (B + 1)) | ((QW+1)'(1) << (2 * B));
		assign ge   = {1'b0, r_in} >= term;

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				r_s[j]   <= ge ? QW'(r_in - term[QW-1:0]) : r_in;
				q_s[j]   <= ge ? (q_in | (RW'(1) << B)) : q_in;
				tag_s[j] <= tag_in_j;
			end
		end
	end

	assign root    = q_s[NS-1];
	assign tag_out = tag_s[NS-1];

endmodule

FILE: hdl/vn_lane.sv
module vn_lane #(
	parameter int COMP_WIDTH    = vn_pkg::COMP_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  vn_pkg::lane_ctl_t                 ctl,
	input  logic [2*COMP_WIDTH-1:0]           sq,
	input  logic [2*COMP_WIDTH-1:0]           sum,
	input  logic                              neg,
	output logic signed [OUT_FRAC_BITS+1:0]   unit
);
	import vn_pkg::*;

	localparam int QW = 2 * OUT_FRAC_BITS + 1;
	localparam int RW = OUT_FRAC_BITS + 1;
	localparam int OW = OUT_FRAC_BITS + 2;

	logic [QW-1:0] quo;
	logic          neg_div;
	logic [RW-1:0] root;
	logic          neg_sqrt;
	logic [OW-1:0] mag_ext;
	logic [OW-1:0] unit_q;

	// floor(sqrt(floor(a/b))) equals floor(sqrt(a/b)) for integers
	vn_div #(
		.COMP_WIDTH   (COMP_WIDTH),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.ctl    (ctl),
		.sq     (sq),
		.sum    (sum),
		.tag_in (neg),
		.quo    (quo),
		.tag_out(neg_div)
	);

	vn_sqrt #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_sqrt (
		.clk    (clk),
		.ctl    (ctl),
		.rad    (quo),
		.tag_in (neg_div),
		.root   (root),
		.tag_out(neg_sqrt)
	);

	assign mag_ext = {1'b0, root};

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			unit_q <= neg_sqrt ? OW'(~mag_ext + 1'b1) : mag_ext;
		end
	end

	assign unit = signed'(unit_q);

endmodule

FILE: hdl/vector_normalize_core.sv
// vector_normalize_core: unit vector of a 3D fixed-point vector.
// Input channel s_t*: one item per handshake, three signed COMP_WIDTH-bit
// components (Q16.16 by default). Output channel m_t*: the unit vector as
// three signed Q1.OUT_FRAC_BITS components truncated toward zero, plus a
// flag in m_tuser that marks a zero-length input (components then zero).
// Throughput: one item per cycle while the skid register is empty. Each
// of the three lanes runs a restoring divider of 2*OUT_FRAC_BITS+1
// stages and a square root of OUT_FRAC_BITS+1 stages, one bit per stage,
// after a magnitude, square and sum front end of three stages.
// Reset clears all valid flags; the pipeline comes up empty with s_tready
// high. When the receiver stalls, one more finished item is parked in a
// skid register and then s_tready drops and the whole pipeline holds until
// m_tready returns; no item is lost or repeated.
module vector_normalize_core #(
	parameter int COMP_WIDTH    = vn_pkg::COMP_WIDTH_DEF,
	parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS_DEF,
	localparam int IN_W  = ((3 * COMP_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((3 * (OUT_FRAC_BITS + 2) + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // comp_x, comp_y, comp_z
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // unit_x, unit_y, unit_z
	output logic             m_tuser    // was_zero
);
	import vn_pkg::*;

	localparam int CW  = COMP_WIDTH;
	localparam int SW  = 2 * COMP_WIDTH;
	localparam int OW  = OUT_FRAC_BITS + 2;
	localparam int LL  = 3 * OUT_FRAC_BITS + 3;
	localparam int LAT = LL + 3;

	lane_ctl_t ctl;
	logic      en;

	logic [CW-1:0] mag_s1 [3];
	logic          neg_s1 [3];
	logic [SW-1:0] sq_s2  [3];
	logic          neg_s2 [3];
	logic [SW-1:0] sq_s3  [3];
	logic          neg_s3 [3];
	logic [SW-1:0] sum_s3;

	logic [LAT-1:0] vld_s;
	logic [LL-1:0]  zero_s;

	logic signed [OW-1:0] unit [3];
	logic [OUT_W-1:0]     fin_data;
	logic                 fin_zero;

	logic             out_v_q;
	logic [OUT_W-1:0] out_d_q;
	logic             out_z_q;
	logic             sk_v_q;
	logic [OUT_W-1:0] sk_d_q;
	logic             sk_z_q;

	assign en       = !sk_v_q;
	assign ctl.en   = en;
	assign s_tready = en;

	// front end: magnitude, square, sum
	for (genvar i = 0; i < 3; i++) begin : g_front
		logic [CW-1:0] raw;
		assign raw = s_tdata[i*CW +: CW];

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s1[i] <= raw[CW-1];
				mag_s1[i] <= raw[CW-1] ? CW'(~raw + 1'b1) : raw;
				sq_s2[i]  <= SW'(mag_s1[i]) * SW'(mag_s1[i]);
				neg_s2[i] <= neg_s1[i];
				sq_s3[i]  <= sq_s2[i];
				neg_s3[i] <= neg_s2[i];
			end
		end

		vn_lane #(
			.COMP_WIDTH   (COMP_WIDTH),
			.OUT_FRAC_BITS(OUT_FRAC_BITS)
		) u_lane (
			.clk (clk),
			.ctl (ctl),
			.sq  (sq_s3[i]),
			.sum (sum_s3),
			.neg (neg_s3[i]),
			.unit(unit[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			zero_s <= {zero_s[LL-2:0], sum_s3 == '0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
		end
	end

	// merge lanes; a zero-length vector forces all components to zero
	assign fin_zero = zero_s[LL-1];
	assign fin_data = fin_zero ? '0 :
		OUT_W'({unit[2], unit[1], unit[0]});

	// output register with skid: park one item while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= vld_s[LAT-1];
			end
		end else if (vld_s[LAT-1] && en) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_d_q <= sk_v_q ? sk_d_q : fin_data;
			out_z_q <= sk_v_q ? sk_z_q : fin_zero;
		end else if (en) begin
			sk_d_q <= fin_data;
			sk_z_q <= fin_zero;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tuser  = out_z_q;

endmodule
